// ===== hdl/nrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrbp_pkg
// shared types and constants of the nearest ray / box pick block
// ----------------------------------------------------------------------------
package nrbp_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [COORD_W-1:0] SAT_HI = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_LO = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_NEXT,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // channel payloads
  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] max_z;
    logic [IDX_W-1:0]   index;
    logic               last;
  } box_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] distance;
  } pick_res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   value;
  } cfg_wr_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;   // take the input beat
    logic       div_start; // start the division of the current slot
    logic       slot_done; // fold the quotient of the current slot
    logic [2:0] slot;      // 0..5: axis*2 + bound
    logic       update;    // fold box result into best
    logic       emit;      // load output register and clear pick
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic last_box;
  } stat_t;

endpackage

// ===== hdl/nrbp_if.sv =====
// ----------------------------------------------------------------------------
// nrbp_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface nrbp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/nrbp_div.sv =====
// ----------------------------------------------------------------------------
// nrbp_div
// shared radix-2 restoring divider, signed, truncating, saturating to 32 bit
// ----------------------------------------------------------------------------
module nrbp_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [32:0]  num,   // bound - origin
  input  logic signed [17:0]  den,
  output logic                busy,
  output logic signed [31:0]  quo
);
  import nrbp_pkg::*;

  localparam int unsigned NW  = 33 + FRACTION_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic [NW-1:0] n_r, n_nxt;
  logic [17:0]   rem_r, rem_nxt;
  logic [17:0]   d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  logic [NW-1:0] anum;
  logic [18:0]   trial;
  logic [NW:0]   mag;
  logic [NW:0]   lim;

  always_comb begin
    anum = NW'({33'(num[32] ? -num : num), {FRACTION_BITS{1'b0}}});
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, n_r[NW-1]} - {1'b0, d_r};
    if (start) begin
      n_nxt    = anum;
      rem_nxt  = '0;
      d_nxt    = 18'(den[17] ? -den : den);
      neg_nxt  = num[32] ^ den[17];
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[18]) begin
        rem_nxt = trial[17:0];
        n_nxt   = {n_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[16:0], n_r[NW-1]};
        n_nxt   = {n_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  // magnitude saturation, negative side reaches one further
  always_comb begin
    mag = {1'b0, n_r};
    lim = (NW+1)'({1'b0, SAT_HI}) + (NW+1)'(neg_r);
    if (mag >= lim) quo = neg_r ? SAT_LO : SAT_HI;
    else            quo = neg_r ? -32'(n_r) : 32'(n_r);
  end

  assign busy = busy_r;
endmodule

// ===== hdl/nrbp_datapath.sv =====
// ----------------------------------------------------------------------------
// nrbp_datapath
// config registers, slab intervals, running best and the output register
// ----------------------------------------------------------------------------
module nrbp_datapath #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [31:0]           cfg_wdata,
  input  logic [31:0]           box_min_x,
  input  logic [31:0]           box_min_y,
  input  logic [31:0]           box_min_z,
  input  logic [31:0]           box_max_x,
  input  logic [31:0]           box_max_y,
  input  logic [31:0]           box_max_z,
  input  logic [9:0]            box_index,
  input  logic                  last_box,
  input  nrbp_pkg::ctrl_t       ctrl,
  output nrbp_pkg::stat_t       stat,
  output logic                  hit_found,
  output logic [9:0]            nearest_index,
  output logic [31:0]           hit_distance
);
  import nrbp_pkg::*;

  logic signed [31:0] org_r [3];
  logic signed [17:0] dir_r [3];
  logic signed [31:0] bnd_r [6];
  logic [9:0]         idx_r;
  logic               last_r;

  logic signed [31:0] tn_r, tf_r, t0_r;
  logic               hit_r;
  logic signed [31:0] best_d_r;
  logic [9:0]         best_i_r;
  logic               any_r;
  logic               of_r;
  logic [9:0]         oi_r;
  logic [31:0]        od_r;

  logic [1:0]         ax;
  logic signed [31:0] o, b, other;
  logic signed [17:0] d;
  logic signed [32:0] num;
  logic signed [31:0] q, an, af, lo, hi;
  logic               div_busy;

  assign ax    = ctrl.slot[2:1];
  assign o     = org_r[ax];
  assign d     = dir_r[ax];
  assign b     = bnd_r[ctrl.slot];
  assign other = bnd_r[{ax, 1'b0}];
  assign num   = 33'(b) - 33'(o);

  nrbp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk, .rst_n, .start(ctrl.div_start), .num, .den(d),
    .busy(div_busy), .quo(q)
  );

  always_comb begin
    an = t0_r;
    af = q;
    if (q < t0_r) begin
      an = q;
      af = t0_r;
    end
    lo = (other < b) ? other : b;
    hi = (other < b) ? b : other;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= '0; dir_r[1] <= '0; dir_r[2] <= 18'sd65536;
      best_d_r <= SAT_HI;
      best_i_r <= '0;
      any_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ORIGIN_X: org_r[0] <= cfg_wdata;
          REG_ORIGIN_Y: org_r[1] <= cfg_wdata;
          REG_ORIGIN_Z: org_r[2] <= cfg_wdata;
          REG_DIR_X:    dir_r[0] <= cfg_wdata[17:0];
          REG_DIR_Y:    dir_r[1] <= cfg_wdata[17:0];
          REG_DIR_Z:    dir_r[2] <= cfg_wdata[17:0];
          default: ;
        endcase
      end
      if (ctrl.update && hit_r && (!any_r || tn_r < best_d_r)) begin
        best_d_r <= tn_r;
        best_i_r <= idx_r;
        any_r    <= 1'b1;
      end
      if (ctrl.emit) begin
        best_d_r <= SAT_HI;
        best_i_r <= '0;
        any_r    <= 1'b0;
      end
    end
    if (ctrl.capture) begin
      bnd_r[0] <= box_min_x; bnd_r[1] <= box_max_x;
      bnd_r[2] <= box_min_y; bnd_r[3] <= box_max_y;
      bnd_r[4] <= box_min_z; bnd_r[5] <= box_max_z;
      idx_r    <= box_index;
      last_r   <= last_box;
      hit_r    <= 1'b1;
    end
    if (ctrl.slot_done) begin
      if (!ctrl.slot[0]) begin
        t0_r <= q;
      end else begin
        // zero direction: the slab is unbounded or the box misses
        if (d == '0) begin
          if (o < lo || o > hi) hit_r <= 1'b0;
        end else if (ax == 2'd0) begin
          tn_r <= an;
          tf_r <= af;
        end else begin
          if (tn_r > af || an > tf_r) hit_r <= 1'b0;
          if (an > tn_r) tn_r <= an;
          if (af < tf_r) tf_r <= af;
        end
        if (d == '0 && ax == 2'd0) begin
          tn_r <= SAT_LO;
          tf_r <= SAT_HI;
        end
      end
    end
    if (ctrl.emit) begin
      of_r <= any_r;
      oi_r <= any_r ? best_i_r : '0;
      od_r <= any_r ? best_d_r : '0;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.last_box = last_r;
  assign hit_found     = of_r;
  assign nearest_index = oi_r;
  assign hit_distance  = od_r;
endmodule

// ===== hdl/nrbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrbp_ctrl
// sequencer: six divisions per box, then best update and optional result
// ----------------------------------------------------------------------------
module nrbp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  nrbp_pkg::stat_t stat,
  output nrbp_pkg::ctrl_t ctrl
);
  import nrbp_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic       ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    ov_nxt    = ov_r && !out_ready;
    ctrl      = '0;
    ctrl.slot = slot_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          slot_nxt     = '0;
          state_nxt    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl.div_start = 1'b1;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          ctrl.slot_done = 1'b1;
          state_nxt      = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (slot_r == 3'd5) begin
          state_nxt = ST_UPDATE;
        end else begin
          slot_nxt  = slot_r + 3'd1;
          state_nxt = ST_LOAD;
        end
      end
      ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_nxt   = stat.last_box ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!ov_r || out_ready) begin
          ctrl.emit = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
endmodule

// ===== hdl/nearest_ray_box_pick.sv =====
// each box takes six divisions (Q16.16 at FRACTION_BITS = 16); the result of
// the last box follows its best update and then the output load
// boxes are taken one at a time, paced by the single shared radix-2 divider
// (one quotient bit per cycle, six quotients per box);
// a stalled result holds the next last box only while the output register is full
// reset: synchronous active low; origin 0, direction (0,0,1), pick state cleared
// ----------------------------------------------------------------------------
// nearest_ray_box_pick
// slab-test ray/box pick returning the nearest hit of a box stream
// ----------------------------------------------------------------------------
module nearest_ray_box_pick #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_box_min_x,
  input  logic [31:0] in_box_min_y,
  input  logic [31:0] in_box_min_z,
  input  logic [31:0] in_box_max_x,
  input  logic [31:0] in_box_max_y,
  input  logic [31:0] in_box_max_z,
  input  logic [9:0]  in_box_index,
  input  logic        in_last_box,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit_found,
  output logic [9:0]  out_nearest_index,
  output logic [31:0] out_hit_distance,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import nrbp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  nrbp_if #(.payload_t(box_t))      in_ch ();
  nrbp_if #(.payload_t(pick_res_t)) out_ch ();
  nrbp_if #(.payload_t(cfg_wr_t))   cfg_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.data  = '{in_box_min_x, in_box_min_y, in_box_min_z,
                         in_box_max_x, in_box_max_y, in_box_max_z,
                         in_box_index, in_last_box};
  assign in_ready    = in_ch.ready;

  assign out_ch.ready      = out_ready;
  assign out_valid         = out_ch.valid;
  assign out_hit_found     = out_ch.data.found;
  assign out_nearest_index = out_ch.data.index;
  assign out_hit_distance  = out_ch.data.distance;

  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.data  = '{cfg_index, cfg_data};
  assign cfg_ch.ready = 1'b1;
  assign cfg_ready    = cfg_ch.ready;

  nrbp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .ctrl
  );

  nrbp_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_ch.valid && cfg_ch.ready), .cfg_idx(cfg_ch.data.index),
    .cfg_wdata(cfg_ch.data.value),
    .box_min_x(in_ch.data.min_x), .box_min_y(in_ch.data.min_y),
    .box_min_z(in_ch.data.min_z),
    .box_max_x(in_ch.data.max_x), .box_max_y(in_ch.data.max_y),
    .box_max_z(in_ch.data.max_z),
    .box_index(in_ch.data.index), .last_box(in_ch.data.last),
    .ctrl, .stat,
    .hit_found(out_ch.data.found), .nearest_index(out_ch.data.index),
    .hit_distance(out_ch.data.distance)
  );
endmodule
